// ===== rtl/core/arv_pkg.sv =====
`timescale 1ns / 1ps

package arv_pkg;

  localparam int COORD_WIDTH    = 24;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int TABLE_FRAC     = 14;

  localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
  localparam int MAG_W   = TRIG_FRAC_BITS + 1;
  localparam int ACC_W   = COORD_WIDTH + TRIG_W + 1;
  localparam int ROUND_W = ACC_W - TRIG_FRAC_BITS;
  localparam int COLOR_W = 32;
  localparam int DATA_W  = ((3 * COORD_WIDTH + COLOR_W + 7) / 8) * 8;

  localparam int SCALE_DN  = (TRIG_FRAC_BITS < TABLE_FRAC) ? TABLE_FRAC - TRIG_FRAC_BITS : 0;
  localparam int SCALE_UP  = (TRIG_FRAC_BITS > TABLE_FRAC) ? TRIG_FRAC_BITS - TABLE_FRAC : 0;
  localparam int SCALE_RND = (1 << SCALE_DN) >> 1;

  localparam int ANGLE_W    = 9;
  localparam int AXIS_W     = 2;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [ANGLE_W-1:0] ANGLE_HALF    = ANGLE_W'(180);
  localparam logic [ANGLE_W-1:0] ANGLE_QUARTER = ANGLE_W'(180 / 2);
  localparam logic [ANGLE_W-1:0] ANGLE_FULL    = ANGLE_W'(2 * 180);

  localparam logic [CFG_ADDR_W-1:0] REG_AXIS  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_ANGLE = CFG_ADDR_W'(1);

  localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1 << TRIG_FRAC_BITS);
  localparam logic signed [TRIG_W-1:0] TRIG_ZERO = '0;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef enum logic [1:0] {
    PAIR_YZ = 2'd0,
    PAIR_ZX = 2'd1,
    PAIR_XY = 2'd2
  } pair_t;

  localparam logic [TABLE_FRAC:0] QUARTER_SINE [0:90] = '{
        0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
     2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
     5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
     8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  function automatic logic [MAG_W-1:0] scale_mag(input logic [TABLE_FRAC:0] t);
    logic [31:0] w;
    w = (32'(t) + 32'(SCALE_RND)) >> SCALE_DN;
    w = w << SCALE_UP;
    return w[MAG_W-1:0];
  endfunction

  // a must be below ANGLE_FULL
  function automatic logic signed [TRIG_W-1:0] sine_deg(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W-1:0] d;
    logic neg;
    logic signed [TRIG_W-1:0] mag;
    neg = 1'b0;
    if (a <= ANGLE_QUARTER) begin
      d = a;
    end else if (a <= ANGLE_HALF) begin
      d = ANGLE_HALF - a;
    end else if (a <= ANGLE_HALF + ANGLE_QUARTER) begin
      d = a - ANGLE_HALF;
      neg = 1'b1;
    end else begin
      d = ANGLE_FULL - a;
      neg = 1'b1;
    end
    mag = $signed({1'b0, scale_mag(QUARTER_SINE[d[6:0]])});
    return neg ? -mag : mag;
  endfunction

endpackage

// ===== rtl/core/axis_rotate_vertex.sv =====
`timescale 1ns / 1ps

// Rotates one vertex per clock about the x, y or z axis by a whole-degree angle, or
// passes it unchanged for axis none; the sustained rate is one vertex every cycle while
// out_tready stays high. A request waits in the input register until the result register
// is free. The path is one input register, the multiply, round and saturate path (four
// 24x16 multipliers in parallel), then the result register. Sine and cosine sit in a
// register of their own recomputed from the configuration every cycle, so a new axis or
// angle goes through the configuration registers, then that register, before it reaches
// requests moving to the result register; write the configuration only while no request
// is in flight. in_tready follows out_tready combinationally when both stages hold data.
module axis_rotate_vertex (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [arv_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [arv_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [arv_pkg::DATA_W-1:0]     in_tdata,   // x_in, y_in, z_in, color_in
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [arv_pkg::DATA_W-1:0]     out_tdata,  // x_out, y_out, z_out, color_out
  output logic                          out_tlast
);

  localparam int CW = arv_pkg::COORD_WIDTH;
  localparam int F  = arv_pkg::TRIG_FRAC_BITS;
  localparam int TW = arv_pkg::TRIG_W;
  localparam int AW = arv_pkg::ACC_W;
  localparam int RW = arv_pkg::ROUND_W;
  localparam int PW = CW + TW;
  localparam int NW = arv_pkg::ANGLE_W;

  localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);
  localparam logic signed [AW-1:0] HALF   = AW'(64'sd1 <<< (F - 1));

  function automatic logic signed [CW-1:0] round_sat(input logic signed [AW-1:0] acc);
    logic signed [AW-1:0] t;
    logic signed [RW-1:0] r;
    t = acc + HALF;
    r = t[AW-1:F];
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return r[CW-1:0];
  endfunction

  arv_pkg::axis_t          axis_r;
  logic [NW-1:0]           angle_r;
  logic signed [TW-1:0]    sin_r, sin_nxt;
  logic signed [TW-1:0]    cos_r, cos_nxt;
  arv_pkg::pair_t          pair_r, pair_nxt;
  logic [NW-1:0]           ang_red, ang_cos;

  logic                    s1_valid_r, s1_valid_nxt;
  logic signed [CW-1:0]    s1_x_r, s1_y_r, s1_z_r;
  logic [arv_pkg::COLOR_W-1:0] s1_color_r;
  logic                    s1_last_r;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [CW-1:0]    out_x_r, out_y_r, out_z_r;
  logic [arv_pkg::COLOR_W-1:0] out_color_r;
  logic                    out_last_r;

  logic                    in_fire, out_load;
  logic signed [CW-1:0]    u, v, u_rot, v_rot;
  logic signed [CW-1:0]    x_nxt, y_nxt, z_nxt;
  logic signed [PW-1:0]    p_cu, p_sv, p_su, p_cv;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r  <= arv_pkg::AXIS_X;
      angle_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        arv_pkg::REG_AXIS:  axis_r  <= arv_pkg::axis_t'(cfg_wdata[arv_pkg::AXIS_W-1:0]);
        arv_pkg::REG_ANGLE: angle_r <= cfg_wdata[NW-1:0];
        default: ;
      endcase
    end
  end

  // trig register
  always_comb begin
    ang_red = (angle_r >= arv_pkg::ANGLE_FULL) ? angle_r - arv_pkg::ANGLE_FULL : angle_r;
    ang_cos = ang_red + arv_pkg::ANGLE_QUARTER;
    if (ang_cos >= arv_pkg::ANGLE_FULL) begin
      ang_cos = ang_cos - arv_pkg::ANGLE_FULL;
    end
    sin_nxt  = arv_pkg::sine_deg(ang_red);
    cos_nxt  = arv_pkg::sine_deg(ang_cos);
    pair_nxt = arv_pkg::PAIR_YZ;
    case (axis_r)
      arv_pkg::AXIS_X: pair_nxt = arv_pkg::PAIR_YZ;
      arv_pkg::AXIS_Y: pair_nxt = arv_pkg::PAIR_ZX;
      arv_pkg::AXIS_Z: pair_nxt = arv_pkg::PAIR_XY;
      default: begin
        sin_nxt = arv_pkg::TRIG_ZERO;
        cos_nxt = arv_pkg::TRIG_ONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sin_r  <= arv_pkg::TRIG_ZERO;
      cos_r  <= arv_pkg::TRIG_ONE;
      pair_r <= arv_pkg::PAIR_YZ;
    end else begin
      sin_r  <= sin_nxt;
      cos_r  <= cos_nxt;
      pair_r <= pair_nxt;
    end
  end

  // flow control
  assign out_load      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready     = !s1_valid_r || out_load;
  assign in_fire       = in_tvalid && in_tready;
  assign s1_valid_nxt  = in_fire ? 1'b1 : (out_load ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x_r     <= in_tdata[CW-1:0];
      s1_y_r     <= in_tdata[2*CW-1:CW];
      s1_z_r     <= in_tdata[3*CW-1:2*CW];
      s1_color_r <= in_tdata[3*CW+arv_pkg::COLOR_W-1:3*CW];
      s1_last_r  <= in_tlast;
    end
  end

  // rotate the selected pair: u' = c*u - s*v, v' = s*u + c*v
  always_comb begin
    case (pair_r)
      arv_pkg::PAIR_ZX: begin
        u = s1_z_r;
        v = s1_x_r;
      end
      arv_pkg::PAIR_XY: begin
        u = s1_x_r;
        v = s1_y_r;
      end
      default: begin
        u = s1_y_r;
        v = s1_z_r;
      end
    endcase
    p_cu  = PW'(cos_r) * PW'(u);
    p_sv  = PW'(sin_r) * PW'(v);
    p_su  = PW'(sin_r) * PW'(u);
    p_cv  = PW'(cos_r) * PW'(v);
    u_rot = round_sat(AW'(p_cu) - AW'(p_sv));
    v_rot = round_sat(AW'(p_su) + AW'(p_cv));
    x_nxt = s1_x_r;
    y_nxt = s1_y_r;
    z_nxt = s1_z_r;
    case (pair_r)
      arv_pkg::PAIR_ZX: begin
        z_nxt = u_rot;
        x_nxt = v_rot;
      end
      arv_pkg::PAIR_XY: begin
        x_nxt = u_rot;
        y_nxt = v_rot;
      end
      default: begin
        y_nxt = u_rot;
        z_nxt = v_rot;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r     <= x_nxt;
      out_y_r     <= y_nxt;
      out_z_r     <= z_nxt;
      out_color_r <= s1_color_r;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = arv_pkg::DATA_W'({out_color_r, out_z_r, out_y_r, out_x_r});

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while result register is empty");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && !$stable(s1_valid_r) || out_valid_r)
    else $error("loaded request did not reach the result register");

  a_x_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && pair_r == arv_pkg::PAIR_YZ |=> out_x_r == $past(s1_x_r))
    else $error("x changed while rotating about x");

  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    sin_r <= arv_pkg::TRIG_ONE && sin_r >= -arv_pkg::TRIG_ONE &&
    cos_r <= arv_pkg::TRIG_ONE && cos_r >= -arv_pkg::TRIG_ONE)
    else $error("sine or cosine out of range");

endmodule

// ===== test/vertex_rotation_checker.sv =====
`timescale 1ns / 1ps

module vertex_rotation_checker
  import arv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,   // x_in, y_in, z_in, color_in
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [DATA_W-1:0]     out_tdata,  // x_out, y_out, z_out, color_out
  input  logic                  out_tlast,
  output int                    mismatches,
  output int                    checked,
  output int                    pending
);

  localparam int W = COORD_WIDTH;

  typedef struct {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
    logic [COLOR_W-1:0]  color;
    logic                last;
  } vertex_t;

  axis_t              axis_r;
  logic [ANGLE_W-1:0] angle_r;
  vertex_t            rotated_q[$];

  function automatic vertex_t unpack(logic [DATA_W-1:0] d, logic last);
    vertex_t v;
    v.x     = d[W-1:0];
    v.y     = d[2*W-1:W];
    v.z     = d[3*W-1:2*W];
    v.color = d[3*W+COLOR_W-1:3*W];
    v.last  = last;
    return v;
  endfunction

  // sine of a whole-degree angle in 0..359 at TRIG_FRAC_BITS fraction bits
  function automatic longint sine_at(int a);
    int     d;
    int     dn;
    bit     neg;
    longint t;
    neg = 0;
    if (a <= 90) begin
      d = a;
    end else if (a <= 180) begin
      d = 180 - a;
    end else if (a <= 270) begin
      d = a - 180;
      neg = 1;
    end else begin
      d = 360 - a;
      neg = 1;
    end
    t = QUARTER_SINE[d];
    dn = TABLE_FRAC - TRIG_FRAC_BITS;
    if (dn > 0) begin
      t = (t + (longint'(1) << (dn - 1))) >>> dn;
    end else begin
      t = t << (-dn);
    end
    return neg ? -t : t;
  endfunction

  function automatic logic signed [W-1:0] round_sat(longint acc);
    longint r;
    longint hi;
    longint lo;
    hi = (longint'(1) << (W - 1)) - 1;
    lo = -hi - 1;
    r = (acc + (longint'(1) << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[W-1:0];
  endfunction

  function automatic vertex_t rotate_vertex(vertex_t v);
    longint  p[3];
    longint  q[3];
    longint  m[3][3];
    longint  s;
    longint  c;
    longint  acc;
    longint  one;
    int      a;
    vertex_t r;
    one = longint'(1) << TRIG_FRAC_BITS;
    a = angle_r;
    if (a >= 360) a -= 360;
    s = sine_at(a);
    c = sine_at((a + 90) % 360);
    p[0] = v.x;
    p[1] = v.y;
    p[2] = v.z;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) m[i][k] = (i == k) ? one : 0;
    case (axis_r)
      AXIS_X: begin
        m[1][1] = c; m[1][2] = -s;
        m[2][1] = s; m[2][2] = c;
      end
      AXIS_Y: begin
        m[0][0] = c; m[0][2] = s;
        m[2][0] = -s; m[2][2] = c;
      end
      AXIS_Z: begin
        m[0][0] = c; m[0][1] = -s;
        m[1][0] = s; m[1][1] = c;
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += m[i][k] * p[k];
      q[i] = acc;
    end
    r.x     = round_sat(q[0]);
    r.y     = round_sat(q[1]);
    r.z     = round_sat(q[2]);
    r.color = v.color;
    r.last  = v.last;
    return r;
  endfunction

  task automatic check_field(string name, logic signed [COLOR_W:0] want,
                             logic signed [COLOR_W:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    vertex_t got;
    vertex_t want;
    if (!rst_n) begin
      axis_r = AXIS_X;
      angle_r = '0;
      rotated_q.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (in_tvalid && in_tready) rotated_q.push_back(rotate_vertex(unpack(in_tdata, in_tlast)));
      if (out_tvalid && out_tready) begin
        got = unpack(out_tdata, out_tlast);
        if (rotated_q.size() == 0) begin
          $error("result with no request waiting: x %0d y %0d z %0d", got.x, got.y, got.z);
          mismatches++;
        end else begin
          want = rotated_q.pop_front();
          check_field("x_out", want.x, got.x);
          check_field("y_out", want.y, got.y);
          check_field("z_out", want.z, got.z);
          check_field("color_out", {1'b0, want.color}, {1'b0, got.color});
          check_field("last_out", {32'd0, want.last}, {32'd0, got.last});
          checked++;
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_AXIS:  axis_r = axis_t'(cfg_wdata[AXIS_W-1:0]);
          REG_ANGLE: angle_r = cfg_wdata[ANGLE_W-1:0];
          default: ;
        endcase
      end
    end
    pending = rotated_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import arv_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam logic signed [W-1:0] C_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] C_MIN = {1'b1, {(W-1){1'b0}}};
  localparam int EDGE_ANGLES[7] = '{0, 90, 180, 270, 359, 360, 511};

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata = '0;   // x_in, y_in, z_in, color_in
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_W-1:0]     out_tdata;       // x_out, y_out, z_out, color_out
  logic                  out_tlast;

  int mismatches;
  int checked;
  int pending;
  int settings;
  bit calm;

  axis_rotate_vertex u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  vertex_rotation_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .mismatches(mismatches), .checked(checked), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_tready <= calm || ($urandom_range(99) >= 19);
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_vertex(logic signed [W-1:0] x, logic signed [W-1:0] y,
                             logic signed [W-1:0] z, logic [COLOR_W-1:0] color,
                             logic last);
    logic [DATA_W-1:0] d;
    while (!calm && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    d = '0;
    d[W-1:0] = x;
    d[2*W-1:W] = y;
    d[3*W-1:2*W] = z;
    d[3*W+COLOR_W-1:3*W] = color;
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // new axis and angle apply once they have passed the config and trig registers
  task automatic set_rotation(axis_t ax, int ang);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= REG_AXIS;
    cfg_wdata <= CFG_DATA_W'(ax);
    @(negedge clk);
    cfg_addr <= REG_ANGLE;
    cfg_wdata <= CFG_DATA_W'(ang);
    @(negedge clk);
    cfg_we <= 1'b0;
    repeat (3) @(negedge clk);
    settings++;
  endtask

  function automatic logic signed [W-1:0] rand_coord();
    case ($urandom_range(9))
      0: return C_MAX;
      1: return C_MIN;
      2, 3: return W'(int'($urandom_range(4000)) - 2000);
      default: return W'($urandom);
    endcase
  endfunction

  task automatic send_random();
    send_vertex(rand_coord(), rand_coord(), rand_coord(), $urandom, $urandom_range(7) == 0);
  endtask

  initial begin
    int n;
    int ang;
    axis_t ax;
    calm = 0;
    settings = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setting: axis x, angle 0
    send_vertex(C_MAX, C_MIN, '0, 32'h0000_0000, 1'b0);
    send_vertex(C_MIN, C_MAX, C_MAX, 32'hFFFF_FFFF, 1'b1);
    // half-LSB products: rounding ties
    set_rotation(AXIS_Z, 30);
    send_vertex(1, 0, 0, 32'h1234_5678, 1'b0);
    send_vertex(0, 1, 0, 32'h8765_4321, 1'b0);
    send_vertex(-1, 0, 0, 32'hA5A5_A5A5, 1'b0);
    send_vertex(0, -1, 0, 32'h5A5A_5A5A, 1'b1);
    // overflow: saturate
    set_rotation(AXIS_Z, 45);
    send_vertex(C_MAX, C_MAX, C_MIN, 32'hFFFF_FFFF, 1'b0);
    send_vertex(C_MIN, C_MIN, C_MAX, 32'h0000_0001, 1'b0);
    send_vertex(C_MAX, C_MIN, 0, 32'h8000_0000, 1'b1);
    set_rotation(AXIS_Y, 135);
    send_vertex(C_MAX, C_MIN, C_MAX, 32'h0F0F_0F0F, 1'b0);
    send_vertex(3, -5, 7, 32'hF0F0_F0F0, 1'b1);
    set_rotation(AXIS_X, 270);
    send_vertex(C_MIN, C_MAX, C_MIN, 32'h0000_FFFF, 1'b0);
    send_vertex(100, -200, 300, 32'hFFFF_0000, 1'b1);
    // no rotation
    set_rotation(AXIS_NONE, 200);
    send_vertex(C_MAX, C_MIN, 12345, 32'hDEAD_BEEF, 1'b1);
    // angles past a full turn wrap
    set_rotation(AXIS_X, 360);
    send_vertex(C_MAX, 256, -256, 32'h1111_1111, 1'b0);
    set_rotation(AXIS_Y, 511);
    send_vertex(C_MIN, C_MAX, 1000, 32'h2222_2222, 1'b0);
    set_rotation(AXIS_Z, 359);
    send_vertex(C_MAX, C_MAX, C_MAX, 32'h3333_3333, 1'b1);

    for (int phase = 0; phase < 24; phase++) begin
      ax = ($urandom_range(9) == 0) ? AXIS_NONE : axis_t'($urandom_range(2));
      ang = ($urandom_range(7) == 0) ? EDGE_ANGLES[$urandom_range(6)] : $urandom_range(511);
      set_rotation(ax, ang);
      calm = (phase == 8);
      n = calm ? 150 : $urandom_range(40, 66);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) == 0) drain();
        send_random();
      end
      calm = 0;
    end

    drain();
    repeat (4) @(negedge clk);
    $display("Rotated %0d vertices under %0d settings: axes x, y, z and none, angles 0 to 511,",
             checked, settings);
    $display("rounding ties, saturation, and random gaps and stalls on both sides.");
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
